>>> rtl/dfw_pkg.sv
// Shared types and constants for the dedup FIFO waitlist.
// Used by dfw_seq and the top level dedup_fifo_waitlist; no dependencies.
package dfw_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned ReqW         = 32;
  localparam int unsigned ItemW        = 44;
  localparam int unsigned EntW         = ReqW + ItemW;

  typedef enum logic [1:0] {
    CmdEnq   = 2'd0,
    CmdDeq   = 2'd1,
    CmdPeek  = 2'd2,
    CmdCount = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatEmpty = 2'd1,
    StatDup   = 2'd2,
    StatFull  = 2'd3
  } status_e;

  // Fixed-width part of one result word; counts travel beside it.
  typedef struct packed {
    status_e           status;
    logic [ReqW-1:0]   front_requester;
    logic [ItemW-1:0]  front_item;
    logic              is_empty;
  } res_t;

endpackage

>>> rtl/dedup_fifo_waitlist.sv
// Top level of the dedup FIFO waitlist: stream ports, entry RAM, sequencer and
// output register. Depends on dfw_pkg, dfw_ram and dfw_seq.
//
// Usage:
//   Each slave-side word is one command (tuser: enqueue, dequeue, peek, count)
//   with a requester id and an item id in tdata. Each command gives exactly
//   one master-side word: status in tuser, and front pair, match count,
//   occupancy and empty flag in tdata.
//   Commands are worked one at a time. Enqueue and count scan the n waiting
//   entries through the registered-read entry RAM, one read a cycle, before the
//   result goes to the output register; an empty line needs no read.
//   Dequeue and peek first read the head entry and then scan: peek scans all
//   n entries, dequeue n - 1 since it leaves the old head out; on an empty line
//   either reads no entry. The scan loop over the RAM sets the rate.
//   A new command is taken once the previous result has moved into the output
//   register, so a waiting result does not hold up the next scan.
//   When the receiver stalls, the output word holds; a second finished result
//   waits in the sequencer and no further command is taken.
//   Reset empties the line (pointers and count to zero) and clears the output
//   valid; the RAM contents are not cleared and are read only once written.
module dedup_fifo_waitlist #(
  parameter  int unsigned DEPTH = dfw_pkg::DefaultDepth,
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned EntW  = dfw_pkg::EntW,
  localparam int unsigned InW   = ((EntW + 7) / 8) * 8,
  localparam int unsigned OutB  = EntW + 2 * CW + 1,
  localparam int unsigned OutW  = ((OutB + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tuser: [1:0] command
  input  logic [1:0]          s_axis_tuser_i,
  // tdata: [31:0] requester_id, [75:32] item_id, zero pad above
  input  logic [InW-1:0]      s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tuser: [1:0] status
  output logic [1:0]          m_axis_tuser_o,
  // tdata: front_requester, front_item, match_count, occupancy, is_empty, zero pad
  output logic [OutW-1:0]     m_axis_tdata_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ReqW  = dfw_pkg::ReqW;
  localparam int unsigned PadW  = OutW - OutB;

  logic                  res_valid, res_ready;
  dfw_pkg::res_t         res;
  logic [CW-1:0]         res_match, res_occ;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [EntW-1:0]       mem_wdata, mem_rdata;

  logic                  out_valid_q;
  logic [1:0]            out_user_q;
  logic [OutW-1:0]       out_data_q;

  dfw_ram #(
    .WIDTH (EntW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dfw_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (dfw_pkg::cmd_e'(s_axis_tuser_i)),
    .in_req_i    (s_axis_tdata_i[ReqW-1:0]),
    .in_item_i   (s_axis_tdata_i[EntW-1:ReqW]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .res_match_o (res_match),
    .res_occ_o   (res_occ),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Load when the output register is empty or being drained this cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_user_q <= res.status;
      out_data_q <= {{PadW{1'b0}}, res.is_empty, res_occ, res_match,
                     res.front_item, res.front_requester};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> rtl/dfw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dfw_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dfw_seq.sv
// Command sequencer: ring pointers, front read, scan of the line through the
// entry RAM, and the append write. Depends on dfw_pkg.
module dfw_seq #(
  parameter  int unsigned DEPTH = dfw_pkg::DefaultDepth,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dfw_pkg::cmd_e               in_cmd_i,
  input  logic [dfw_pkg::ReqW-1:0]    in_req_i,
  input  logic [dfw_pkg::ItemW-1:0]   in_item_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output dfw_pkg::res_t               res_o,
  output logic [CW-1:0]               res_match_o,
  output logic [CW-1:0]               res_occ_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [dfw_pkg::EntW-1:0]    mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [dfw_pkg::EntW-1:0]    mem_rdata_i
);

  localparam int unsigned ReqW = dfw_pkg::ReqW;
  localparam int unsigned EntW = dfw_pkg::EntW;

  typedef enum logic [1:0] {
    StIdle,
    StFront,
    StScan,
    StDone
  } state_e;

  state_e                    state_q;
  logic [AW-1:0]             head_q, tail_q, scan_ptr_q;
  logic [CW-1:0]             cnt_q, rem_q, match_q, occ_q;
  logic                      pend_q, dup_q;
  dfw_pkg::cmd_e             cmd_q;
  logic [ReqW-1:0]           req_q, front_req_q;
  logic [dfw_pkg::ItemW-1:0] item_q, front_item_q;
  dfw_pkg::status_e          status_q;

  logic accept;
  logic scan_end;
  logic line_full;
  logic item_hit, pair_hit;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign scan_end   = (state_q == StScan) && (rem_q == '0) && !pend_q;
  assign line_full  = (cnt_q == CW'(DEPTH));
  assign item_hit   = (mem_rdata_i[EntW-1:ReqW] == item_q);
  assign pair_hit   = item_hit && (mem_rdata_i[ReqW-1:0] == req_q);

  // Head read on accept of a dequeue or peek on a non-empty line, else one scan read a cycle.
  assign mem_re_o = ((state_q == StScan) && (rem_q != '0)) ||
                    (accept && ((in_cmd_i == dfw_pkg::CmdDeq) ||
                                (in_cmd_i == dfw_pkg::CmdPeek)) && (cnt_q != '0));
  assign mem_raddr_o = (state_q == StIdle) ? head_q : scan_ptr_q;

  assign mem_we_o    = scan_end && (cmd_q == dfw_pkg::CmdEnq) && !dup_q && !line_full;
  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = {item_q, req_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      rem_q      <= '0;
      pend_q     <= 1'b0;
      scan_ptr_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            cmd_q        <= in_cmd_i;
            req_q        <= in_req_i;
            item_q       <= in_item_i;
            match_q      <= '0;
            dup_q        <= 1'b0;
            pend_q       <= 1'b0;
            front_req_q  <= '0;
            front_item_q <= '0;
            occ_q        <= cnt_q;
            case (in_cmd_i)
              dfw_pkg::CmdDeq, dfw_pkg::CmdPeek: begin
                if (cnt_q == '0) begin
                  status_q <= dfw_pkg::StatEmpty;
                  state_q  <= StDone;
                end else begin
                  status_q <= dfw_pkg::StatOk;
                  state_q  <= StFront;
                end
              end
              default: begin
                status_q   <= dfw_pkg::StatOk;
                scan_ptr_q <= head_q;
                rem_q      <= cnt_q;
                state_q    <= StScan;
              end
            endcase
          end
        end
        StFront: begin
          front_req_q  <= mem_rdata_i[ReqW-1:0];
          front_item_q <= mem_rdata_i[EntW-1:ReqW];
          // Dequeue counts over the line without its old head.
          if (cmd_q == dfw_pkg::CmdDeq) begin
            head_q     <= next_ptr(head_q);
            cnt_q      <= cnt_q - 1'b1;
            scan_ptr_q <= next_ptr(head_q);
            rem_q      <= cnt_q - 1'b1;
          end else begin
            scan_ptr_q <= head_q;
            rem_q      <= cnt_q;
          end
          state_q <= StScan;
        end
        StScan: begin
          if (rem_q != '0) begin
            scan_ptr_q <= next_ptr(scan_ptr_q);
            rem_q      <= rem_q - 1'b1;
          end
          pend_q <= (rem_q != '0);
          if (pend_q) begin
            if (item_hit) begin
              match_q <= match_q + 1'b1;
            end
            if (pair_hit) begin
              dup_q <= 1'b1;
            end
          end
          if (scan_end) begin
            state_q <= StDone;
            if ((cmd_q == dfw_pkg::CmdEnq) && !dup_q && !line_full) begin
              // The appended pair matches its own item.
              tail_q  <= next_ptr(tail_q);
              cnt_q   <= cnt_q + 1'b1;
              occ_q   <= cnt_q + 1'b1;
              match_q <= match_q + 1'b1;
            end else begin
              occ_q <= cnt_q;
              if (cmd_q == dfw_pkg::CmdEnq) begin
                status_q <= dup_q ? dfw_pkg::StatDup : dfw_pkg::StatFull;
              end
            end
          end
        end
        StDone: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_valid_o            = (state_q == StDone);
  assign res_o.status           = status_q;
  assign res_o.front_requester  = front_req_q;
  assign res_o.front_item       = front_item_q;
  assign res_o.is_empty         = (occ_q == '0);
  assign res_match_o            = match_q;
  assign res_occ_o              = occ_q;

endmodule
